FILE: src/sst_pkg.sv
package sst_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 6;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int VAL_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_DUMP   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_ELEMENT   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_SHDN,
        S_SHUP,
        S_INS,
        S_RESP,
        S_DUMP
    } t_state;

    typedef struct packed {
        t_kind                    kind;
        logic signed [VAL_W-1:0]  value;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  element;
        logic                     last;
    } t_out;

endpackage

FILE: src/sorted_set_table.sv
// Insert, remove and search scan the sorted entries with one memory read per cycle, then
// insert and remove shift the entries above the slot with one read and one write per cycle.
// A dump of count entries streams one transaction per cycle while the output is not stalled.
// The next input transaction can be taken in the same cycle that the result appears in the output register.
// Reset is synchronous and active low: the count clears and capacity returns to 32; the
// entry memory is not cleared, since only entries below the count are ever read.
module sorted_set_table
    import sst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data
);

    t_state             r_state, n_state;
    t_in                r_op, n_op;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_found, n_found;
    t_status            r_status, n_status;
    logic [CAP_W-1:0]   r_capacity;
    logic               r_out_valid, n_out_valid;
    t_out               r_out;

    logic                    mem_we, mem_re;
    logic [IDX_W-1:0]        mem_waddr, mem_raddr;
    logic signed [VAL_W-1:0] mem_wdata, mem_rdata;

    logic             in_acc, out_free, out_load;
    t_out             out_data;
    logic [CNT_W-1:0] idx_nxt;
    logic             hit_eq, hit_gt, is_full;

    sst_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign idx_nxt = CNT_W'(r_idx) + CNT_W'(1);
    assign hit_eq  = (mem_rdata == r_op.value);
    assign hit_gt  = (mem_rdata > r_op.value);
    assign is_full = (r_count == CNT_W'(DEPTH)) ||
                     (CMP_W'(r_count) >= CMP_W'(r_capacity));

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_count   = r_count;
        n_found   = r_found;
        n_status  = r_status;
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        out_load  = 1'b0;
        out_data  = '{status: ST_DONE, element: '0, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = i_in_data;
                    n_idx = '0;
                    if (i_in_data.kind == KIND_DUMP) begin
                        if (r_count != '0) begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_state   = S_DUMP;
                        end
                    end else if (r_count == '0) begin
                        n_found = 1'b0;
                        n_pos   = '0;
                        n_state = S_EXEC;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit_eq) begin
                    n_found = 1'b1;
                    n_pos   = CNT_W'(r_idx);
                    n_state = S_EXEC;
                end else if (hit_gt) begin
                    n_found = 1'b0;
                    n_pos   = CNT_W'(r_idx);
                    n_state = S_EXEC;
                end else if (idx_nxt == r_count) begin
                    n_found = 1'b0;
                    n_pos   = r_count;
                    n_state = S_EXEC;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(idx_nxt);
                    n_idx     = IDX_W'(idx_nxt);
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (r_op.kind)
                    KIND_SEARCH: begin
                        n_status = r_found ? ST_DONE : ST_NOT_FOUND;
                    end
                    KIND_REMOVE: begin
                        if (!r_found) begin
                            n_status = ST_NOT_FOUND;
                        end else if (r_pos + CNT_W'(1) < r_count) begin
                            mem_re    = 1'b1;
                            mem_raddr = IDX_W'(r_pos + CNT_W'(1));
                            n_idx     = IDX_W'(r_pos + CNT_W'(1));
                            n_state   = S_SHDN;
                        end else begin
                            n_count  = r_count - CNT_W'(1);
                            n_status = ST_DONE;
                        end
                    end
                    default: begin
                        if (r_found) begin
                            n_status = ST_DUPLICATE;
                        end else if (is_full) begin
                            n_status = ST_FULL;
                        end else if (r_pos < r_count) begin
                            mem_re    = 1'b1;
                            mem_raddr = IDX_W'(r_count - CNT_W'(1));
                            n_idx     = IDX_W'(r_count - CNT_W'(1));
                            n_state   = S_SHUP;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = IDX_W'(r_pos);
                            mem_wdata = r_op.value;
                            n_count   = r_count + CNT_W'(1);
                            n_status  = ST_DONE;
                        end
                    end
                endcase
            end
            S_SHDN: begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(CNT_W'(r_idx) - CNT_W'(1));
                if (idx_nxt < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(idx_nxt);
                    n_idx     = IDX_W'(idx_nxt);
                end else begin
                    n_count  = r_count - CNT_W'(1);
                    n_status = ST_DONE;
                    n_state  = S_RESP;
                end
            end
            S_SHUP: begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(idx_nxt);
                if (CNT_W'(r_idx) == r_pos) begin
                    n_state = S_INS;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx - IDX_W'(1);
                    n_idx     = r_idx - IDX_W'(1);
                end
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(r_pos);
                mem_wdata = r_op.value;
                n_count   = r_count + CNT_W'(1);
                n_status  = ST_DONE;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = '{status: r_status, element: '0, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = '{status: ST_ELEMENT, element: mem_rdata,
                                 last: (idx_nxt == r_count)};
                    if (idx_nxt == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(idx_nxt);
                        n_idx     = IDX_W'(idx_nxt);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = out_load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_status <= n_status;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the store depth.");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE))
        else $error("Memory write while idle.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CNT_W'(1)) ||
             (r_count == $past(r_count) - CNT_W'(1))))
        else $error("Entry count changed by more than one.");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_DUMP)) |-> (CNT_W'(r_idx) < r_count))
        else $error("Read index beyond the stored entries.");

endmodule

FILE: src/sst_mem.sv
module sst_mem
    import sst_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [IDX_W-1:0]        i_waddr,
    input  logic signed [VAL_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [IDX_W-1:0]        i_raddr,
    output logic signed [VAL_W-1:0] o_rdata
);

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
